// ===== rtl/ship_pkg.sv =====
// Shared constants and row types for the SHiP/SRRIP replacement block.
// No dependencies; used by ship_rrip_replacement and ship_rrip_checker.
package ship_pkg;

    localparam int WAYS       = 8;
    localparam int WAY_W      = 3;
    localparam int SETS       = 1024;
    localparam int SET_W      = 10;
    localparam int SIG_W      = 14;
    localparam int TAG_W      = 32;
    localparam int SLOTS      = 512;
    localparam int SLOT_W     = 9;
    localparam int SIGMEM_W   = 15;
    localparam int SEED_W     = 26;

    localparam logic [1:0]        RRPV_MAX  = 2'd3;
    localparam logic [1:0]        RRPV_INS  = 2'd2;
    localparam logic [14:0]       SIG_PRIME = 15'd16381;
    localparam logic [2:0]        SIG_MAX   = 3'd7;
    localparam logic [63:0]       LCG_MULT  = 64'd1103515245;
    localparam logic [63:0]       LCG_INC   = 64'd12345;

    typedef logic [WAYS-1:0][1:0] t_rrpv_row;

    typedef struct packed {
        logic [WAYS-1:0]             valid;
        logic [WAYS-1:0]             used;
        logic [WAYS-1:0][TAG_W-1:0]  tag;
        logic [WAYS-1:0][SIG_W-1:0]  sig;
        logic [WAYS-1:0][WAY_W-1:0]  age;
    } t_samp_row;

    // slot map entry: sampled flag and sampler slot
    typedef struct packed {
        logic              sampled;
        logic [SLOT_W-1:0] slot;
    } t_slot_ent;

endpackage

// ===== rtl/ship_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; read during write to the same address returns old data.
module ship_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/ship_rrip_replacement.sv =====
// SHiP replacement policy on 2-bit RRIP counters, top level.
// Depends on ship_pkg and ship_ram (RRPV, signature, sampler, slot map memories).
// Victim requests and writebacks finish in S_LOOK, unsampled updates go through S_LOOK
// and S_FIN, sampled updates through S_LOOK, S_SAMP, S_ADJ and S_FIN (sampler row read,
// counter read-modify-write, counter read, RRPV write). One request at a time; busy is
// high from accept until the result strobe cycle. Reset: a clearing pass sweeps the
// memories, then the sampled-set map is built from the LCG; busy stays high meanwhile.
module ship_rrip_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic        i_cpu,
    input  logic [9:0]  i_set_index,
    input  logic [2:0]  i_way,
    input  logic [7:0]  i_valid_mask,
    input  logic [47:0] i_address,
    input  logic [47:0] i_pc,
    input  logic        i_is_writeback,
    input  logic        i_hit,
    output logic        o_done,
    output logic [2:0]  o_victim_way
);

    typedef enum logic [3:0] {
        S_CLEAR, S_GEN, S_CHK, S_IDLE, S_LOOK, S_SAMP, S_ADJ, S_FIN
    } t_state;

    typedef enum logic [1:0] { ADJ_NONE, ADJ_INC, ADJ_DEC } t_adj;

    t_state r_state;
    logic   r_func, r_cpu, r_hit, r_wb;
    logic [ship_pkg::SET_W-1:0]  r_set;
    logic [ship_pkg::WAY_W-1:0]  r_way;
    logic [7:0]                  r_mask;
    logic [ship_pkg::TAG_W-1:0]  r_tag;
    logic [17:0]                 r_fold;
    logic [ship_pkg::SIG_W-1:0]  r_sig;
    ship_pkg::t_rrpv_row         r_row;
    t_adj                        r_adj;
    logic [ship_pkg::SIGMEM_W-1:0] r_addr_a;
    logic [2:0]                  r_newval;
    logic                        r_fwd;
    logic [ship_pkg::SIGMEM_W:0] r_clr;
    logic [ship_pkg::SEED_W-1:0] r_seed;
    logic [ship_pkg::SET_W-1:0]  r_cand;
    logic [ship_pkg::SLOT_W:0]   r_count;
    logic                        r_done;
    logic [2:0]                  r_victim;

    // memory ports
    logic rr_we, sl_we, sm_we, sg_we;
    logic [ship_pkg::SET_W-1:0]    rr_waddr, rr_raddr, sl_waddr, sl_raddr;
    ship_pkg::t_rrpv_row           rr_wdata, rr_q;
    ship_pkg::t_slot_ent           sl_wdata, sl_q;
    logic [ship_pkg::SLOT_W-1:0]   sm_waddr, sm_raddr;
    ship_pkg::t_samp_row           sm_wdata, sm_q, samp_rst;
    logic [ship_pkg::SIGMEM_W-1:0] sg_waddr, sg_raddr;
    logic [2:0]                    sg_wdata, sg_q;

    ship_ram #(.WIDTH($bits(ship_pkg::t_rrpv_row)), .DEPTH(1024)) u_rrpv (
        .i_clk(i_clk), .i_we(rr_we), .i_waddr(rr_waddr), .i_wdata(rr_wdata),
        .i_raddr(rr_raddr), .o_rdata(rr_q));
    ship_ram #(.WIDTH($bits(ship_pkg::t_slot_ent)), .DEPTH(1024)) u_slot (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_raddr(sl_raddr), .o_rdata(sl_q));
    ship_ram #(.WIDTH($bits(ship_pkg::t_samp_row)), .DEPTH(512)) u_samp (
        .i_clk(i_clk), .i_we(sm_we), .i_waddr(sm_waddr), .i_wdata(sm_wdata),
        .i_raddr(sm_raddr), .o_rdata(sm_q));
    ship_ram #(.WIDTH(3), .DEPTH(32768)) u_sig (
        .i_clk(i_clk), .i_we(sg_we), .i_waddr(sg_waddr), .i_wdata(sg_wdata),
        .i_raddr(sg_raddr), .o_rdata(sg_q));

    // pc mod 16381: 16384 = 3 (mod 16381), so 14-bit chunks fold with powers of 3
    logic [17:0] fold_c;
    logic [14:0] fold2;
    logic [ship_pkg::SIG_W-1:0] sig_c;
    always_comb begin
        fold_c = 18'(i_pc[13:0]) + 18'(i_pc[27:14]) * 18'd3 + 18'(i_pc[41:28]) * 18'd9
               + 18'(i_pc[47:42]) * 18'd27;
        fold2  = 15'(r_fold[13:0]) + 15'(r_fold[17:14]) * 15'd3;
        sig_c  = (fold2 >= ship_pkg::SIG_PRIME) ? 14'(fold2 - ship_pkg::SIG_PRIME)
                                                : fold2[13:0];
    end

    // LCG, kept modulo 2^26 since only bits 16..25 feed the candidate
    logic [ship_pkg::SEED_W-1:0] n_seed;
    assign n_seed = r_seed * ship_pkg::LCG_MULT[ship_pkg::SEED_W-1:0]
                  + ship_pkg::LCG_INC[ship_pkg::SEED_W-1:0];

    // victim search
    logic                inv_any;
    logic [2:0]          inv_way, vic_way;
    logic [1:0]          top;
    ship_pkg::t_rrpv_row aged;
    always_comb begin
        inv_any = 1'b0;
        inv_way = '0;
        top     = '0;
        vic_way = '0;
        for (int w = ship_pkg::WAYS - 1; w >= 0; w--) begin
            if (!r_mask[w]) begin
                inv_any = 1'b1;
                inv_way = 3'(w);
            end
        end
        for (int w = 0; w < ship_pkg::WAYS; w++) begin
            if (rr_q[w] > top) top = rr_q[w];
        end
        for (int w = 0; w < ship_pkg::WAYS; w++) begin
            aged[w] = rr_q[w] + (ship_pkg::RRPV_MAX - top);
        end
        for (int w = ship_pkg::WAYS - 1; w >= 0; w--) begin
            if (rr_q[w] == top) vic_way = 3'(w);
        end
    end

    // sampler training on the row just read
    logic                 m_any, f_any;
    logic [2:0]           m_way, f_way, e_way, pick;
    t_adj                 adj_c;
    logic [ship_pkg::SIGMEM_W-1:0] addr_a_c;
    ship_pkg::t_samp_row  samp_new;
    always_comb begin
        m_any = 1'b0; m_way = '0; f_any = 1'b0; f_way = '0; e_way = '0;
        for (int w = ship_pkg::WAYS - 1; w >= 0; w--) begin
            if (sm_q.valid[w] && sm_q.tag[w] == r_tag) begin
                m_any = 1'b1;
                m_way = 3'(w);
            end
            if (!sm_q.valid[w]) begin
                f_any = 1'b1;
                f_way = 3'(w);
            end
            if (sm_q.age[w] == 3'(ship_pkg::WAYS - 1)) e_way = 3'(w);
        end
        samp_new = sm_q;
        addr_a_c = {r_cpu, r_sig};
        adj_c    = ADJ_NONE;
        if (m_any) begin
            pick = m_way;
            adj_c = ADJ_DEC;
            samp_new.used[pick] = 1'b1;
        end else begin
            pick = f_any ? f_way : e_way;
            if (!f_any && !sm_q.used[pick]) begin
                adj_c    = ADJ_INC;
                addr_a_c = {r_cpu, sm_q.sig[pick]};
            end
            samp_new.valid[pick] = 1'b1;
            samp_new.tag[pick]   = r_tag;
            samp_new.sig[pick]   = r_sig;
            samp_new.used[pick] = 1'b0;
        end
        for (int w = 0; w < ship_pkg::WAYS; w++) begin
            if (sm_q.age[w] < sm_q.age[pick]) samp_new.age[w] = sm_q.age[w] + 3'd1;
        end
        samp_new.age[pick] = '0;
    end

    logic [2:0] cnt_new, cnt_fin;
    always_comb begin
        cnt_new = sg_q;
        case (r_adj)
            ADJ_INC: if (sg_q != ship_pkg::SIG_MAX) cnt_new = sg_q + 3'd1;
            ADJ_DEC: if (sg_q != 3'd0) cnt_new = sg_q - 3'd1;
            default: cnt_new = sg_q;
        endcase
        cnt_fin = r_fwd ? r_newval : sg_q;
    end

    always_comb begin
        samp_rst = '0;
        for (int w = 0; w < ship_pkg::WAYS; w++) begin
            samp_rst.age[w] = 3'(w);
        end
    end

    // memory control
    always_comb begin
        rr_we = 1'b0; rr_waddr = r_set; rr_wdata = r_row; rr_raddr = i_set_index;
        sl_we = 1'b0; sl_waddr = r_cand; sl_wdata = '0; sl_raddr = i_set_index;
        sm_we = 1'b0; sm_waddr = sl_q.slot; sm_wdata = samp_new; sm_raddr = sl_q.slot;
        sg_we = 1'b0; sg_waddr = r_addr_a; sg_wdata = cnt_new; sg_raddr = {r_cpu, sig_c};
        case (r_state)
            S_CLEAR: begin
                sg_we    = 1'b1;
                sg_waddr = r_clr[ship_pkg::SIGMEM_W-1:0];
                sg_wdata = '0;
                rr_we    = (r_clr[ship_pkg::SIGMEM_W-1:ship_pkg::SET_W] == '0);
                rr_waddr = r_clr[ship_pkg::SET_W-1:0];
                rr_wdata = '1;
                sl_we    = rr_we;
                sl_waddr = r_clr[ship_pkg::SET_W-1:0];
                sm_we    = (r_clr[ship_pkg::SIGMEM_W-1:ship_pkg::SLOT_W] == '0);
                sm_waddr = r_clr[ship_pkg::SLOT_W-1:0];
                sm_wdata = samp_rst;
            end
            S_GEN: begin
                sl_raddr = n_seed[25:16];
            end
            S_CHK: begin
                sl_we    = !sl_q.sampled;
                sl_wdata = {1'b1, r_count[ship_pkg::SLOT_W-1:0]};
            end
            S_LOOK: begin
                if (!r_func) begin
                    rr_we    = inv_any ? 1'b0 : 1'b1;
                    rr_wdata = aged;
                end else if (r_wb) begin
                    rr_we    = !r_hit;
                    rr_wdata = rr_q;
                    rr_wdata[r_way] = ship_pkg::RRPV_INS;
                end
            end
            S_SAMP: begin
                sm_we    = 1'b1;
                sm_waddr = r_addr_a[ship_pkg::SLOT_W-1:0];
                sm_raddr = r_addr_a[ship_pkg::SLOT_W-1:0];
                sg_raddr = addr_a_c;
            end
            S_ADJ: begin
                sg_we    = (r_adj != ADJ_NONE);
                sg_raddr = {r_cpu, r_sig};
            end
            S_FIN: begin
                rr_we = 1'b1;
                rr_wdata[r_way] = r_hit ? 2'd0 :
                    ((cnt_fin == ship_pkg::SIG_MAX) ? ship_pkg::RRPV_MAX : ship_pkg::RRPV_INS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_seed  <= ship_pkg::SEED_W'(1);
            r_count <= '0;
            r_done  <= 1'b0;
            r_adj   <= ADJ_NONE;
            r_fwd   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (ship_pkg::SIGMEM_W+1)'(32767)) r_state <= S_GEN;
                end
                S_GEN: begin
                    r_seed  <= n_seed;
                    r_cand  <= n_seed[25:16];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_GEN;
                    if (!sl_q.sampled) begin
                        r_count <= r_count + 1'b1;
                        if (r_count == (ship_pkg::SLOT_W+1)'(ship_pkg::SLOTS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_func  <= i_func;
                        r_cpu   <= i_cpu;
                        r_set   <= i_set_index;
                        r_way   <= i_way;
                        r_mask  <= i_valid_mask;
                        r_tag   <= i_address[47:16];
                        r_wb    <= i_is_writeback;
                        r_hit   <= i_hit;
                        r_fold  <= fold_c;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_sig    <= sig_c;
                    r_row    <= rr_q;
                    r_fwd    <= 1'b0;
                    r_addr_a <= ship_pkg::SIGMEM_W'(sl_q.slot);
                    if (!r_func) begin
                        r_done   <= 1'b1;
                        r_victim <= inv_any ? inv_way : vic_way;
                        r_state  <= S_IDLE;
                    end else if (r_wb) begin
                        r_done   <= 1'b1;
                        r_victim <= '0;
                        r_state  <= S_IDLE;
                    end else if (sl_q.sampled) begin
                        r_state <= S_SAMP;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SAMP: begin
                    r_adj    <= adj_c;
                    r_addr_a <= addr_a_c;
                    r_state  <= S_ADJ;
                end
                S_ADJ: begin
                    // counter read at the same cycle as its write sees old data
                    r_fwd    <= (r_addr_a == {r_cpu, r_sig});
                    r_newval <= cnt_new;
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    r_done   <= 1'b1;
                    r_victim <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_victim_way = r_victim;

endmodule

// ===== tb/sv/ship_test_pkg.sv =====
// Request codes shared by the SHiP replacement testbench files.
// No dependencies; used by ship_rrip_checker and ship_rrip_replacement_test.
package ship_test_pkg;

    typedef enum logic {
        FN_VICTIM = 1'b0,
        FN_UPDATE = 1'b1
    } t_func;

endpackage

// ===== tb/sv/ship_rrip_checker.sv =====
// Checker for ship_rrip_replacement: tracks RRPV, signature and sampler state,
// predicts each victim way and compares it. Depends on ship_pkg, ship_test_pkg.
module ship_rrip_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_func,
    input  logic        i_cpu,
    input  logic [9:0]  i_set_index,
    input  logic [2:0]  i_way,
    input  logic [7:0]  i_valid_mask,
    input  logic [47:0] i_address,
    input  logic [47:0] i_pc,
    input  logic        i_is_writeback,
    input  logic        i_hit,
    input  logic        i_done,
    input  logic [2:0]  i_victim_way,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIG_ENTRIES = 16384;
    localparam int EXP_DEPTH   = 64;

    logic [1:0]                 rrpv_q   [ship_pkg::SETS][ship_pkg::WAYS];
    logic [2:0]                 sig_ctr  [2][SIG_ENTRIES];
    logic                       smp_vld  [ship_pkg::SLOTS][ship_pkg::WAYS];
    logic                       smp_used [ship_pkg::SLOTS][ship_pkg::WAYS];
    logic [ship_pkg::TAG_W-1:0] smp_tag  [ship_pkg::SLOTS][ship_pkg::WAYS];
    logic [ship_pkg::SIG_W-1:0] smp_sig  [ship_pkg::SLOTS][ship_pkg::WAYS];
    logic [2:0]                 smp_age  [ship_pkg::SLOTS][ship_pkg::WAYS];
    int                         slot_of  [ship_pkg::SETS];   // slot + 1, 0 when not sampled
    logic [2:0]                 exp_fifo [EXP_DEPTH];
    int                         wr_cnt, rd_cnt;

    initial begin
        longint unsigned s;
        int n, cand;
        s = 1;
        n = 0;
        o_fail_count = 0;
        wr_cnt = 0;
        rd_cnt = 0;
        for (int i = 0; i < ship_pkg::SETS; i++) begin
            slot_of[i] = 0;
            for (int w = 0; w < ship_pkg::WAYS; w++) rrpv_q[i][w] = ship_pkg::RRPV_MAX;
        end
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < SIG_ENTRIES; i++) sig_ctr[b][i] = '0;
        for (int i = 0; i < ship_pkg::SLOTS; i++)
            for (int w = 0; w < ship_pkg::WAYS; w++) begin
                smp_vld[i][w] = 0;
                smp_used[i][w] = 0;
                smp_tag[i][w] = '0;
                smp_sig[i][w] = '0;
                smp_age[i][w] = 3'(w);
            end
        while (n < ship_pkg::SLOTS) begin
            s = s * 64'd1103515245 + 64'd12345;
            cand = int'((s >> 16) & 64'hFFFFF) % ship_pkg::SETS;
            if (slot_of[cand] == 0) begin
                n++;
                slot_of[cand] = n;
            end
        end
    end

    assign o_pending = wr_cnt - rd_cnt;

    function automatic void train_sampler(int slot, int bank, logic [47:0] addr, int sig);
        logic [ship_pkg::TAG_W-1:0] tag;
        int pick, cur;
        tag = addr[47:16];
        pick = -1;
        for (int w = 0; w < ship_pkg::WAYS; w++)
            if (pick < 0 && smp_vld[slot][w] && smp_tag[slot][w] == tag) begin
                if (sig_ctr[bank][sig] != 0) sig_ctr[bank][sig]--;
                smp_used[slot][w] = 1;
                pick = w;
            end
        for (int w = 0; w < ship_pkg::WAYS; w++)
            if (pick < 0 && !smp_vld[slot][w]) begin
                smp_vld[slot][w] = 1;
                smp_tag[slot][w] = tag;
                smp_sig[slot][w] = ship_pkg::SIG_W'(sig);
                smp_used[slot][w] = 0;
                pick = w;
            end
        if (pick < 0) begin
            pick = 0;
            for (int w = 1; w < ship_pkg::WAYS; w++)
                if (smp_age[slot][w] > smp_age[slot][pick]) pick = w;
            // evicting an unreused entry marks its signature as dead-on-arrival
            if (!smp_used[slot][pick] &&
                sig_ctr[bank][smp_sig[slot][pick]] != ship_pkg::SIG_MAX)
                sig_ctr[bank][smp_sig[slot][pick]]++;
            smp_tag[slot][pick] = tag;
            smp_sig[slot][pick] = ship_pkg::SIG_W'(sig);
            smp_used[slot][pick] = 0;
        end
        cur = smp_age[slot][pick];
        for (int w = 0; w < ship_pkg::WAYS; w++)
            if (smp_age[slot][w] < cur) smp_age[slot][w]++;
        smp_age[slot][pick] = 0;
    endfunction

    function automatic logic [2:0] predict_victim(ship_test_pkg::t_func fn, int bank, int set,
                                                  int way, logic [7:0] mask,
                                                  logic [47:0] addr, logic [47:0] pc,
                                                  logic wb, logic hit);
        logic [1:0] top;
        int sig;
        if (fn == ship_test_pkg::FN_VICTIM) begin
            for (int w = 0; w < ship_pkg::WAYS; w++)
                if (!mask[w]) return 3'(w);
            top = 0;
            for (int w = 0; w < ship_pkg::WAYS; w++)
                if (rrpv_q[set][w] > top) top = rrpv_q[set][w];
            for (int w = 0; w < ship_pkg::WAYS; w++) rrpv_q[set][w] += ship_pkg::RRPV_MAX - top;
            for (int w = 0; w < ship_pkg::WAYS; w++)
                if (rrpv_q[set][w] == ship_pkg::RRPV_MAX) return 3'(w);
            return 3'd0;
        end
        if (wb) begin
            if (!hit) rrpv_q[set][way] = ship_pkg::RRPV_INS;
            return 3'd0;
        end
        sig = int'(longint'({16'd0, pc}) % 16381);
        if (slot_of[set] != 0) train_sampler(slot_of[set] - 1, bank, addr, sig);
        if (hit) rrpv_q[set][way] = 2'd0;
        else rrpv_q[set][way] = (sig_ctr[bank][sig] == ship_pkg::SIG_MAX) ?
                                ship_pkg::RRPV_MAX : ship_pkg::RRPV_INS;
        return 3'd0;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        logic [2:0] exp_way;
        if (i_rst_n && i_done) begin
            if (wr_cnt == rd_cnt) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                exp_way = exp_fifo[rd_cnt % EXP_DEPTH];
                rd_cnt++;
                if (i_victim_way !== exp_way)
                    report_mismatch($sformatf("victim_way got %0d expected %0d",
                                              i_victim_way, exp_way));
            end
        end
        if (i_rst_n && start && !busy) begin
            exp_fifo[wr_cnt % EXP_DEPTH] = predict_victim(ship_test_pkg::t_func'(i_func),
                int'(i_cpu), int'(i_set_index), int'(i_way), i_valid_mask, i_address, i_pc,
                i_is_writeback, i_hit);
            wr_cnt++;
        end
    end

endmodule

// ===== tb/sv/ship_rrip_replacement_test.sv =====
// Top of the ship_rrip_replacement testbench: clock, reset, request stimulus, verdict.
// Depends on ship_pkg, ship_test_pkg, ship_rrip_checker and the block itself.
module ship_rrip_replacement_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQS = 1450;
    localparam int STALL_LIMIT = 150000;   // covers the post-reset clearing pass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        start = 0;
    logic        busy;
    logic        i_func = 0;
    logic        i_cpu = 0;
    logic [9:0]  i_set_index = '0;
    logic [2:0]  i_way = '0;
    logic [7:0]  i_valid_mask = '0;
    logic [47:0] i_address = '0;
    logic [47:0] i_pc = '0;
    logic        i_is_writeback = 0;
    logic        i_hit = 0;
    logic        o_done;
    logic [2:0]  o_victim_way;
    int          fail_count, pending;
    int          stall_cycles = 0;
    int          n_victim = 0, n_update = 0;

    logic [31:0] tag_pool [12];
    logic [47:0] pc_pool  [4];
    logic [9:0]  set_pool [16];

    always #5 i_clk = ~i_clk;

    ship_rrip_replacement i_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_cpu, .i_set_index, .i_way,
        .i_valid_mask, .i_address, .i_pc, .i_is_writeback, .i_hit, .o_done, .o_victim_way
    );

    ship_rrip_checker i_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_func, .i_cpu, .i_set_index, .i_way,
        .i_valid_mask, .i_address, .i_pc, .i_is_writeback, .i_hit,
        .i_done(o_done), .i_victim_way(o_victim_way),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("ship_rrip_replacement test failed");
            $finish;
        end
    end

    // holds start high until the request is taken; drops it only when a gap follows
    task automatic send_request(ship_test_pkg::t_func fn, logic cpu, logic [9:0] set,
                                logic [2:0] way, logic [7:0] mask, logic [47:0] addr,
                                logic [47:0] pc, logic wb, logic hit, int gap);
        start <= 1;
        i_func <= fn;
        i_cpu <= cpu;
        i_set_index <= set;
        i_way <= way;
        i_valid_mask <= mask;
        i_address <= addr;
        i_pc <= pc;
        i_is_writeback <= wb;
        i_hit <= hit;
        do @(posedge i_clk); while (busy);
        if (fn == ship_test_pkg::FN_VICTIM) n_victim++;
        else n_update++;
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        ship_test_pkg::t_func fn;
        logic [9:0] set;
        logic [7:0] mask;
        logic [47:0] addr, pc;
        int gap;
        for (int i = 0; i < 12; i++) tag_pool[i] = $urandom;
        for (int i = 0; i < 4; i++) pc_pool[i] = {16'($urandom), 32'($urandom)};
        for (int i = 0; i < 16; i++) set_pool[i] = 10'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: invalid-way lookup, fresh full set, each update flavor, aging
        send_request(ship_test_pkg::FN_VICTIM, 0, 10'd0,    3'd0, 8'h00, '0, '0, 0, 0, 0);
        send_request(ship_test_pkg::FN_VICTIM, 1, 10'd1023, 3'd7, 8'h7F, '1, '1, 1, 1, 1);
        send_request(ship_test_pkg::FN_VICTIM, 0, 10'd5,    3'd0, 8'hFF, '0, '0, 0, 0, 0);
        send_request(ship_test_pkg::FN_UPDATE, 0, 10'd5,    3'd0, 8'hFF, 48'h1_0000, 48'd42,
                     0, 1, 0);
        send_request(ship_test_pkg::FN_UPDATE, 1, 10'd5,    3'd7, 8'hFF, '1, '1, 0, 0, 2);
        send_request(ship_test_pkg::FN_UPDATE, 0, 10'd5,    3'd3, 8'hFF, 48'h5_0000, 48'd7,
                     1, 1, 0);
        send_request(ship_test_pkg::FN_UPDATE, 0, 10'd5,    3'd4, 8'hFF, 48'h5_0000, 48'd7,
                     1, 0, 0);
        send_request(ship_test_pkg::FN_VICTIM, 0, 10'd5,    3'd0, 8'hFF, '0, '0, 0, 0, 1);
        send_request(ship_test_pkg::FN_UPDATE, 1, 10'd0,    3'd7, 8'hFF, '0, 48'd16381,
                     0, 1, 0);
        send_request(ship_test_pkg::FN_UPDATE, 0, 10'd1023, 3'd0, 8'hFF, '1, 48'd16380,
                     0, 0, 0);
        send_request(ship_test_pkg::FN_VICTIM, 1, 10'd1023, 3'd0, 8'hFF, '0, '0, 0, 0, 3);
        send_request(ship_test_pkg::FN_VICTIM, 0, 10'd1023, 3'd0, 8'hEF, '0, '0, 0, 0, 0);
        // many unreused tags with one pc on one set; if the set is sampled, evictions raise its counter
        for (int i = 0; i < 10; i++)
            send_request(ship_test_pkg::FN_UPDATE, 0, set_pool[0], 3'(i), 8'hFF,
                         {32'(i * 977 + 1), 16'h0}, pc_pool[0], 0, 0, 0);

        for (int i = 0; i < RANDOM_REQS; i++) begin
            fn = ($urandom_range(0, 99) < 40) ? ship_test_pkg::FN_VICTIM
                                              : ship_test_pkg::FN_UPDATE;
            set = ($urandom_range(0, 9) == 0) ? 10'($urandom) : set_pool[$urandom_range(0, 15)];
            mask = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hFF;
            addr = {tag_pool[$urandom_range(0, 11)], 16'($urandom)};
            if ($urandom_range(0, 9) == 0) addr = {16'($urandom), 32'($urandom)};
            pc = ($urandom_range(0, 4) == 0) ? {16'($urandom), 32'($urandom)}
                                             : pc_pool[$urandom_range(0, 3)];
            gap = 0;
            if ((i < 600 || i > 900) && $urandom_range(0, 99) < 19)
                gap = $urandom_range(1, 6);
            if (i == 700) begin
                // let the block drain completely before going on
                start <= 0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_request(fn, 1'($urandom), set, 3'($urandom), mask, addr, pc,
                         $urandom_range(0, 99) < 15, 1'($urandom), gap);
        end
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d victim lookups and %0d state updates", n_victim, n_update);
        $display("on a small pool of sets, tags and pcs plus scattered full-range values");
        if (fail_count == 0) begin
            $display("ship_rrip_replacement test passed");
        end else begin
            $display("ship_rrip_replacement test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ship_pkg.sv
rtl/ship_ram.sv
rtl/ship_rrip_replacement.sv
tb/sv/ship_test_pkg.sv
tb/sv/ship_rrip_checker.sv
tb/sv/ship_rrip_replacement_test.sv
